### design/isrca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrca_pkg: shared types and constants
// Payload structs, register indexes and sequencer states for the
// interval-sampled range-checked average block.
// ----------------------------------------------------------------------------
package isrca_pkg;

  localparam int TIME_W  = 32;
  localparam int VAL_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  // quotient bits produced by the shared divider (averages fit in 16 bits)
  localparam int QUO_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_MIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_MAX        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_MIN         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_MAX         = 3'd6;

  localparam logic [TIME_W-1:0] SAMPLE_INTERVAL_RST = 32'd15000;
  localparam logic [TIME_W-1:0] REPORT_INTERVAL_RST = 32'd60000;
  localparam logic [VAL_W-1:0]  TEMP_MIN_RST        = 16'hFE70;  // -40.0
  localparam logic [VAL_W-1:0]  TEMP_MAX_RST        = 16'd800;   // 80.0
  localparam logic [VAL_W-1:0]  HUM_MIN_RST         = 16'd0;
  localparam logic [VAL_W-1:0]  HUM_MAX_RST         = 16'd1000;  // 100.0

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                    command;
    logic [TIME_W-1:0]       now_ms;
    logic signed [VAL_W-1:0] temperature_tenths;
    logic                    temperature_ok;
    logic [VAL_W-1:0]        humidity_tenths;
    logic                    humidity_ok;
  } in_item_t;

  typedef struct packed {
    logic                    sampled;
    logic                    temp_accepted;
    logic                    hum_accepted;
    logic signed [VAL_W-1:0] last_temperature;
    logic [VAL_W-1:0]        last_humidity;
    logic                    report_valid;
    logic signed [VAL_W-1:0] avg_temperature;
    logic [VAL_W-1:0]        avg_humidity;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV_T_LD,
    ST_DIV_T,
    ST_DIV_H_LD,
    ST_DIV_H,
    ST_OUT
  } state_t;

endpackage

### design/interval_sampled_range_checked_average_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_sampled_range_checked_average_top
// Interval sampling of range-checked readings with windowed block averages.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one poll (start or tick command, time and
//   two readings). out_valid/out_ready/out_data return exactly one result per
//   poll. cfg_valid/cfg_ready/cfg_index/cfg_data write the seven registers;
//   cfg_ready is always high and writes belong in idle periods.
// Sequencing:
//   a poll without a report goes from the input register through ST_EVAL to
//   ST_OUT; a report poll runs the shared restoring divider twice (temperature,
//   then humidity), 16 quotient bits at one bit per cycle after a load state
//   each, before ST_OUT. One poll is handled at a time: in_ready is high only
//   when the block is idle, so no new poll is taken until the result of the
//   last one has been taken.
// Reset:
//   synchronous active-low rst_n restores the register defaults and clears
//   the reference times, last values, window sums and counts.
// Stall:
//   the result is held in out_data until out_ready; no new poll is taken
//   meanwhile.
// ----------------------------------------------------------------------------
module interval_sampled_range_checked_average_top
  import isrca_pkg::*;
#(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int TSW = 17 + $clog2(MAX_SAMPLES);
  localparam int HSW = 16 + $clog2(MAX_SAMPLES);
  localparam int DW  = TSW;
  localparam int QCW = $clog2(QUO_W);

  state_t state_r, state_nxt;

  logic [TIME_W-1:0]       sample_interval_r;
  logic [TIME_W-1:0]       report_interval_r;
  logic                    report_enable_r;
  logic signed [VAL_W-1:0] temp_min_r;
  logic signed [VAL_W-1:0] temp_max_r;
  logic [VAL_W-1:0]        hum_min_r;
  logic [VAL_W-1:0]        hum_max_r;

  logic [TIME_W-1:0]       last_sample_time_r;
  logic [TIME_W-1:0]       last_report_time_r;
  logic signed [VAL_W-1:0] last_temp_r;
  logic [VAL_W-1:0]        last_hum_r;
  logic [TSW-1:0]          temp_sum_r;
  logic [HSW-1:0]          hum_sum_r;
  logic [CW-1:0]           temp_count_r;
  logic [CW-1:0]           hum_count_r;

  in_item_t  in_q_r;
  out_item_t out_q_r;

  // shared divider
  logic [CW:0]      div_rem_r;
  logic [QUO_W-1:0] div_dvd_r;
  logic [QUO_W-1:0] div_quo_r;
  logic [CW-1:0]    div_dsr_r;
  logic [QCW-1:0]   div_cnt_r;

  logic [CW:0]      div_trial;
  logic             div_ge;
  logic [CW:0]      div_rem_nxt;
  logic [QUO_W-1:0] div_quo_nxt;
  logic [DW-1:0]    div_src;
  logic [DW-1:0]    div_src_shr;
  logic [TSW-1:0]   temp_abs;
  logic [VAL_W-1:0] temp_avg;

  logic                    samp_due;
  logic                    rep_due;
  logic                    t_valid;
  logic                    h_valid;
  logic                    is_tick;
  logic                    t_acc;
  logic                    h_acc;
  logic                    do_rep;
  logic signed [VAL_W-1:0] t_in;
  logic [TSW-1:0]          t_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = out_q_r;

  // poll evaluation
  always_comb begin
    t_in     = $signed(in_q_r.temperature_tenths);
    t_ext    = {{(TSW-VAL_W){t_in[VAL_W-1]}}, t_in};
    is_tick  = (in_q_r.command == CMD_TICK);
    samp_due = (in_q_r.now_ms - last_sample_time_r) >= sample_interval_r;
    rep_due  = report_enable_r &&
               ((in_q_r.now_ms - last_report_time_r) >= report_interval_r);
    t_valid  = in_q_r.temperature_ok && (t_in >= temp_min_r) && (t_in <= temp_max_r);
    h_valid  = in_q_r.humidity_ok && (in_q_r.humidity_tenths >= hum_min_r) &&
               (in_q_r.humidity_tenths <= hum_max_r);
    t_acc    = is_tick && samp_due && t_valid;
    h_acc    = is_tick && samp_due && h_valid;
    do_rep   = is_tick && rep_due;
  end

  // one restoring division step per cycle
  always_comb begin
    div_trial   = {div_rem_r[CW-1:0], div_dvd_r[QUO_W-1]};
    div_ge      = div_trial >= {1'b0, div_dsr_r};
    div_rem_nxt = div_ge ? (div_trial - {1'b0, div_dsr_r}) : div_trial;
    div_quo_nxt = {div_quo_r[QUO_W-2:0], div_ge};
    temp_abs    = temp_sum_r[TSW-1] ? (~temp_sum_r + {{(TSW-1){1'b0}}, 1'b1}) : temp_sum_r;
    div_src     = (state_r == ST_DIV_T_LD) ? temp_abs : DW'(hum_sum_r);
    div_src_shr = div_src >> QUO_W;
    temp_avg    = temp_sum_r[TSW-1] ? (~div_quo_nxt + {{(VAL_W-1){1'b0}}, 1'b1})
                                    : div_quo_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_EVAL;
      ST_EVAL:     state_nxt = do_rep ? ST_DIV_T_LD : ST_OUT;
      ST_DIV_T_LD: state_nxt = ST_DIV_T;
      ST_DIV_T:    if (div_cnt_r == '0) state_nxt = ST_DIV_H_LD;
      ST_DIV_H_LD: state_nxt = ST_DIV_H;
      ST_DIV_H:    if (div_cnt_r == '0) state_nxt = ST_OUT;
      ST_OUT:      if (out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_interval_r  <= SAMPLE_INTERVAL_RST;
      report_interval_r  <= REPORT_INTERVAL_RST;
      report_enable_r    <= 1'b0;
      temp_min_r         <= TEMP_MIN_RST;
      temp_max_r         <= TEMP_MAX_RST;
      hum_min_r          <= HUM_MIN_RST;
      hum_max_r          <= HUM_MAX_RST;
      last_sample_time_r <= '0;
      last_report_time_r <= '0;
      last_temp_r        <= '0;
      last_hum_r         <= '0;
      temp_sum_r         <= '0;
      hum_sum_r          <= '0;
      temp_count_r       <= '0;
      hum_count_r        <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SAMPLE_INTERVAL: sample_interval_r <= cfg_data;
          REG_REPORT_INTERVAL: report_interval_r <= cfg_data;
          REG_REPORT_ENABLE:   report_enable_r   <= cfg_data[0];
          REG_TEMP_MIN:        temp_min_r        <= cfg_data[VAL_W-1:0];
          REG_TEMP_MAX:        temp_max_r        <= cfg_data[VAL_W-1:0];
          REG_HUM_MIN:         hum_min_r         <= cfg_data[VAL_W-1:0];
          REG_HUM_MAX:         hum_max_r         <= cfg_data[VAL_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_EVAL) begin
        if (!is_tick) begin
          last_sample_time_r <= in_q_r.now_ms;
          last_report_time_r <= in_q_r.now_ms;
        end else begin
          if (samp_due) last_sample_time_r <= in_q_r.now_ms;
          if (do_rep)   last_report_time_r <= in_q_r.now_ms;
          if (t_acc) begin
            last_temp_r <= t_in;
            // full window keeps the last value but drops the sample
            if (temp_count_r < CW'(MAX_SAMPLES)) begin
              temp_sum_r   <= temp_sum_r + t_ext;
              temp_count_r <= temp_count_r + {{(CW-1){1'b0}}, 1'b1};
            end
          end
          if (h_acc) begin
            last_hum_r <= in_q_r.humidity_tenths;
            if (hum_count_r < CW'(MAX_SAMPLES)) begin
              hum_sum_r   <= hum_sum_r + HSW'(in_q_r.humidity_tenths);
              hum_count_r <= hum_count_r + {{(CW-1){1'b0}}, 1'b1};
            end
          end
        end
      end
      if ((state_r == ST_DIV_H) && (div_cnt_r == '0)) begin
        temp_sum_r   <= '0;
        hum_sum_r    <= '0;
        temp_count_r <= '0;
        hum_count_r  <= '0;
      end
    end
  end

  // payload and divider datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) in_q_r <= in_data;
      end
      ST_EVAL: begin
        out_q_r.sampled          <= is_tick && samp_due;
        out_q_r.temp_accepted    <= t_acc;
        out_q_r.hum_accepted     <= h_acc;
        out_q_r.last_temperature <= t_acc ? t_in : last_temp_r;
        out_q_r.last_humidity    <= h_acc ? in_q_r.humidity_tenths : last_hum_r;
        out_q_r.report_valid     <= do_rep;
        out_q_r.avg_temperature  <= '0;
        out_q_r.avg_humidity     <= '0;
      end
      ST_DIV_T_LD, ST_DIV_H_LD: begin
        // upper dividend bits are already below the divisor
        div_rem_r <= div_src_shr[CW:0];
        div_dvd_r <= div_src[QUO_W-1:0];
        div_quo_r <= '0;
        div_dsr_r <= (state_r == ST_DIV_T_LD) ? temp_count_r : hum_count_r;
        div_cnt_r <= QCW'(QUO_W - 1);
      end
      ST_DIV_T, ST_DIV_H: begin
        div_rem_r <= div_rem_nxt;
        div_dvd_r <= {div_dvd_r[QUO_W-2:0], 1'b0};
        div_quo_r <= div_quo_nxt;
        div_cnt_r <= div_cnt_r - {{(QCW-1){1'b0}}, 1'b1};
        if (div_cnt_r == '0) begin
          if (state_r == ST_DIV_T) begin
            out_q_r.avg_temperature <= (temp_count_r == '0) ? '0 : temp_avg;
          end else begin
            out_q_r.avg_humidity <= (hum_count_r == '0) ? '0 : div_quo_nxt;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
